// ===== rtl/core/cltrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex lower triangular solve package
// Shared payload structs and request, status and config codes.
// ----------------------------------------------------------------------------
package cltrs_pkg;

    localparam logic [1:0] REQ_LOAD_L = 2'd0;
    localparam logic [1:0] REQ_LOAD_A = 2'd1;
    localparam logic [1:0] REQ_START  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic CFG_N_ROWS = 1'b0;
    localparam logic CFG_N_COLS = 1'b1;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [31:0] value_re;
        logic signed [31:0] value_im;
    } t_req;

    typedef struct packed {
        logic [2:0]         out_row;
        logic [2:0]         out_col;
        logic signed [31:0] y_re;
        logic signed [31:0] y_im;
        logic [1:0]         status;
        logic               last;
    } t_rsp;

endpackage

// ===== rtl/core/cltrs_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned quotient of a 66-bit numerator by a 65-bit denominator, rounded
// half up at 16 fraction bits; one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cltrs_div
    import cltrs_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_go,
    input  logic [65:0]  i_num,
    input  logic [64:0]  i_den,
    output logic         o_done,
    output logic [81:0]  o_quo
);
    localparam int NB = 82;

    logic [81:0] r_num;
    logic [65:0] r_rem;
    logic [81:0] r_q;
    logic [64:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [66:0] w_trial;
    logic [66:0] w_rem2;

    assign w_rem2  = {r_rem, r_num[NB-1]};
    assign w_trial = w_rem2 - {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= {i_num, 16'b0};
                r_rem  <= '0;
                r_q    <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_num <= {r_num[NB-2:0], 1'b0};
                if (!w_trial[66]) begin
                    r_rem <= w_trial[65:0];
                    r_q   <= {r_q[NB-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem2[65:0];
                    r_q   <= {r_q[NB-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'(NB - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // round: remainder doubled against the divisor
    assign o_done = r_done;
    assign o_quo  = r_q + 82'(({1'b0, r_rem} << 1) >= {2'b0, r_den});

endmodule

// ===== rtl/core/complex_lower_triangular_solve_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex lower triangular solve
// Y = inv(L) * A by forward substitution over Q16.16 complex stores.
// ----------------------------------------------------------------------------
// channel   | direction | handshake            | word
// request   | in        | i_start / o_busy     | t_req
// result    | out       | o_rsp_valid (strobe) | t_rsp
// config    | in        | i_cfg_valid/o_cfg_ready | index, data
//
// A solve reads each row's diagonal, then per column divides twice on the
// bit-serial divider (82 quotient bits each; a zero diagonal writes zero and
// skips the updates), writes the result and updates each row below; then the
// elements are emitted column by column. The divider is shared by both divisions.
// o_busy drops in the cycle that shows the last result. Reset is synchronous;
// the stores are not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
module complex_lower_triangular_solve_top
    import cltrs_pkg::*;
#(
    parameter int MAX_ORDER  = 8,
    parameter int MAX_COLS   = 8,
    parameter int COMP_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_req        i_req,
    output logic        o_busy,
    output logic        o_rsp_valid,
    output t_rsp        o_rsp,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    output logic        o_cfg_ready
);
    localparam int RB = $clog2(MAX_ORDER);
    localparam int CB = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int LD = MAX_ORDER * MAX_ORDER;
    localparam int YD = MAX_ORDER * MAX_COLS;
    localparam int LA = $clog2(LD);
    localparam int YA = $clog2(YD);
    localparam logic signed [63:0] LIM_P = 64'sd1 <<< (COMP_WIDTH - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DREAD, S_DWAIT, S_YREAD, S_YWAIT, S_MUL, S_DIVR, S_DIVI,
        S_WR, S_KREAD, S_KWAIT, S_KMUL, S_KWR, S_OREAD, S_OWAIT
    } t_state;

    function automatic logic signed [63:0] sat(input logic signed [66:0] v);
        if (v > 67'(LIM_P - 1))      return LIM_P - 1;
        else if (v < -67'(LIM_P))    return -LIM_P;
        else                         return 64'(v);
    endfunction

    function automatic logic is_sat(input logic signed [66:0] v);
        return (v > 67'(LIM_P - 1)) || (v < -67'(LIM_P));
    endfunction

    logic [63:0] r_lmem [LD];
    logic [63:0] r_ymem [YD];
    logic [63:0] r_lrd, r_yrd;

    t_state r_state;
    logic [3:0] r_nrows, r_ncols;
    logic [RB:0] r_i, r_k, r_n;
    logic [CB:0] r_j, r_m;
    logic [1:0] r_err;
    logic signed [31:0] r_dre, r_dim, r_y1re, r_y1im, r_lkre;
    logic signed [63:0] r_p0, r_p1, r_p2, r_p3;
    logic [64:0] r_den;
    logic r_nre_neg, r_nim_neg;
    logic [65:0] r_nre_mag, r_nim_mag;
    logic r_go, r_emit;
    logic [LA-1:0] r_la;
    logic [YA-1:0] r_ya;
    logic r_we;
    logic [63:0] r_wd;
    logic [YA-1:0] r_wa;

    logic w_done;
    logic [81:0] w_quo;
    logic [65:0] w_num;
    logic [RB:0] w_n;
    logic [CB:0] w_m;
    logic [4:0]  w_nc, w_mc;
    logic signed [31:0] w_cre, w_cim;

    cltrs_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (r_go),
        .i_num  (w_num),
        .i_den  (r_den),
        .o_done (w_done),
        .o_quo  (w_quo)
    );

    assign w_num = (r_state == S_DIVR) ? r_nre_mag : r_nim_mag;
    assign w_nc  = (r_nrows == 4'd0) ? 5'd1 :
                   ({1'b0, r_nrows} > 5'(MAX_ORDER)) ? 5'(MAX_ORDER)
                                                     : {1'b0, r_nrows};
    assign w_mc  = (r_ncols == 4'd0) ? 5'd1 :
                   ({1'b0, r_ncols} > 5'(MAX_COLS)) ? 5'(MAX_COLS)
                                                    : {1'b0, r_ncols};
    assign w_n   = (RB + 1)'(w_nc);
    assign w_m   = (CB + 1)'(w_mc);
    assign w_cre = 32'(sat({{35{i_req.value_re[31]}}, i_req.value_re}));
    assign w_cim = 32'(sat({{35{i_req.value_im[31]}}, i_req.value_im}));

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    // memories
    always_ff @(posedge i_clk) begin
        r_lrd <= r_lmem[r_la];
        r_yrd <= r_ymem[r_ya];
        if (i_start && !o_busy && i_req.req_type == REQ_LOAD_L
                && 32'(i_req.row) < MAX_ORDER && 32'(i_req.col) < MAX_ORDER)
            r_lmem[LA'(32'(i_req.row) * MAX_ORDER + 32'(i_req.col))] <= {w_cre, w_cim};
        if (i_start && !o_busy && i_req.req_type == REQ_LOAD_A
                && 32'(i_req.row) < MAX_ORDER && 32'(i_req.col) < MAX_COLS)
            r_ymem[YA'(32'(i_req.row) * MAX_COLS + 32'(i_req.col))] <= {w_cre, w_cim};
        else if (r_we)
            r_ymem[r_wa] <= r_wd;
    end

    logic signed [66:0] w_sre, w_sim, w_ure, w_uim;
    logic signed [31:0] w_yre, w_yim;
    logic signed [64:0] w_qre, w_qim;
    assign w_yre = r_yrd[63:32];
    assign w_yim = r_yrd[31:0];
    // update sums: y*2^16 - (lk*y1) terms, rounded half away
    assign w_sre = ({{35{w_yre[31]}}, w_yre} <<< 16) - 67'(r_p0) + 67'(r_p1);
    assign w_sim = ({{35{w_yim[31]}}, w_yim} <<< 16) - 67'(r_p2) - 67'(r_p3);
    assign w_ure = w_sre[66] ? -((-w_sre + 67'sd32768) >>> 16)
                             : ((w_sre + 67'sd32768) >>> 16);
    assign w_uim = w_sim[66] ? -((-w_sim + 67'sd32768) >>> 16)
                             : ((w_sim + 67'sd32768) >>> 16);
    // numerators y * conj(d)
    assign w_qre = 65'(r_p0) + 65'(r_p1);
    assign w_qim = 65'(r_p2) - 65'(r_p3);

    logic signed [66:0] w_qs;
    assign w_qs = (w_quo[81:66] != '0) ? 67'sh1_0000_0000_0000_0000
                                       : {1'b0, w_quo[65:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nrows     <= 4'd8;
            r_ncols     <= 4'd8;
            r_err       <= '0;
            r_go        <= 1'b0;
            r_we        <= 1'b0;
            o_rsp_valid <= 1'b0;
            r_emit      <= 1'b0;
        end else begin
            r_go        <= 1'b0;
            r_we        <= 1'b0;
            o_rsp_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_N_ROWS) r_nrows <= i_cfg_data;
                else                           r_ncols <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start && i_req.req_type == REQ_START) begin
                        r_n     <= w_n;
                        r_m     <= w_m;
                        r_err   <= '0;
                        r_i     <= '0;
                        r_state <= S_DREAD;
                    end
                end
                S_DREAD: begin
                    r_la    <= LA'(32'(r_i) * (MAX_ORDER + 1));
                    r_j     <= '0;
                    r_state <= S_DWAIT;
                end
                S_DWAIT: r_state <= S_MUL;
                S_MUL: begin
                    // first pass: latch diagonal and its squared magnitude
                    if (r_j == '0 && r_emit == 1'b0) begin
                        r_dre  <= r_lrd[63:32];
                        r_dim  <= r_lrd[31:0];
                        r_p0   <= $signed(r_lrd[63:32]) * $signed(r_lrd[63:32]);
                        r_p1   <= $signed(r_lrd[31:0]) * $signed(r_lrd[31:0]);
                        r_emit <= 1'b1;
                    end else begin
                        r_den   <= 65'(r_p0) + 65'(r_p1);
                        r_emit  <= 1'b0;
                        r_state <= S_YREAD;
                    end
                end
                S_YREAD: begin
                    r_ya    <= YA'(32'(r_i) * MAX_COLS + 32'(r_j));
                    r_state <= S_YWAIT;
                end
                S_YWAIT: begin
                    if (r_den == '0) begin
                        r_err[0] <= 1'b1;
                        r_we     <= 1'b1;
                        r_wa     <= r_ya;
                        r_wd     <= '0;
                        r_state  <= S_WR;
                    end else if (!r_emit) begin
                        r_emit <= 1'b1;
                    end else begin
                        r_p0 <= w_yre * r_dre;
                        r_p1 <= w_yim * r_dim;
                        r_p2 <= w_yim * r_dre;
                        r_p3 <= w_yre * r_dim;
                        r_emit  <= 1'b0;
                        r_state <= S_DIVR;
                        r_lkre  <= '0;
                    end
                end
                S_DIVR: begin
                    if (r_lkre == '0) begin
                        r_nre_neg <= w_qre[64];
                        r_nre_mag <= 66'(w_qre[64] ? -w_qre : w_qre);
                        r_nim_neg <= w_qim[64];
                        r_nim_mag <= 66'(w_qim[64] ? -w_qim : w_qim);
                        r_lkre    <= 32'sd1;
                        r_go      <= 1'b1;
                    end else if (w_done) begin
                        if (is_sat(r_nre_neg ? -w_qs : w_qs)) r_err[1] <= 1'b1;
                        r_y1re  <= 32'(sat(r_nre_neg ? -w_qs : w_qs));
                        r_go    <= 1'b1;
                        r_state <= S_DIVI;
                    end
                end
                S_DIVI: begin
                    if (w_done) begin
                        if (is_sat(r_nim_neg ? -w_qs : w_qs)) r_err[1] <= 1'b1;
                        r_y1im  <= 32'(sat(r_nim_neg ? -w_qs : w_qs));
                        r_we    <= 1'b1;
                        r_wa    <= r_ya;
                        r_wd    <= {r_y1re, 32'(sat(r_nim_neg ? -w_qs : w_qs))};
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    r_k     <= r_i + 1'b1;
                    r_state <= (r_den == '0) ? S_KWR : S_KREAD;
                end
                S_KREAD: begin
                    if (r_k >= r_n) begin
                        r_state <= S_KWR;
                    end else begin
                        r_la    <= LA'(32'(r_k) * MAX_ORDER + 32'(r_i));
                        r_ya    <= YA'(32'(r_k) * MAX_COLS + 32'(r_j));
                        r_state <= S_KWAIT;
                    end
                end
                S_KWAIT: begin
                    if (!r_emit) begin
                        r_emit <= 1'b1;
                    end else begin
                        r_emit <= 1'b0;
                        r_p0 <= $signed(r_lrd[63:32]) * r_y1re;
                        r_p1 <= $signed(r_lrd[31:0]) * r_y1im;
                        r_p2 <= $signed(r_lrd[63:32]) * r_y1im;
                        r_p3 <= $signed(r_lrd[31:0]) * r_y1re;
                        r_state <= S_KMUL;
                    end
                end
                S_KMUL: begin
                    if (is_sat(w_ure) || is_sat(w_uim)) r_err[1] <= 1'b1;
                    r_we    <= 1'b1;
                    r_wa    <= r_ya;
                    r_wd    <= {32'(sat(w_ure)), 32'(sat(w_uim))};
                    r_k     <= r_k + 1'b1;
                    r_state <= S_KREAD;
                end
                S_KWR: begin
                    // advance column, then row, then emit
                    if (r_j + 1'b1 < r_m) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_YREAD;
                    end else if (r_i + 1'b1 < r_n) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_DREAD;
                    end else begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_state <= S_OREAD;
                    end
                end
                S_OREAD: begin
                    r_ya    <= YA'(32'(r_i) * MAX_COLS + 32'(r_j));
                    r_state <= S_OWAIT;
                end
                S_OWAIT: begin
                    if (!r_emit) begin
                        r_emit <= 1'b1;
                    end else begin
                        r_emit <= 1'b0;
                        o_rsp_valid     <= 1'b1;
                        o_rsp.out_row   <= 3'(r_i);
                        o_rsp.out_col   <= 3'(r_j);
                        o_rsp.y_re      <= r_yrd[63:32];
                        o_rsp.y_im      <= r_yrd[31:0];
                        o_rsp.status    <= r_err[0] ? ST_ZERO
                                                    : (r_err[1] ? ST_SAT : ST_OK);
                        o_rsp.last      <= (r_i + 1'b1 == r_n) && (r_j + 1'b1 == r_m);
                        if (r_i + 1'b1 < r_n) begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_OREAD;
                        end else if (r_j + 1'b1 < r_m) begin
                            r_i     <= '0;
                            r_j     <= r_j + 1'b1;
                            r_state <= S_OREAD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/cltrs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port checker
// Watches the top level's ports for result sequencing.
// ----------------------------------------------------------------------------
module cltrs_checker
    import cltrs_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_rsp_valid,
    input t_rsp o_rsp,
    input logic o_cfg_ready
);
    a_rsp_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.last) |-> o_busy) else $error("result while idle");
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !o_busy) else $error("config ready while busy");
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.last) |-> !o_busy) else $error("busy at last");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.status == ST_OK || o_rsp.status == ST_ZERO ||
                         o_rsp.status == ST_SAT)) else $error("bad status");
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_busy && !i_start) |=> !o_busy) else $error("busy without start");
endmodule

bind complex_lower_triangular_solve_top cltrs_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_rsp_valid(o_rsp_valid), .o_rsp(o_rsp), .o_cfg_ready(o_cfg_ready)
);

// ===== dv/tb_complex_lower_triangular_solve_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex lower triangular solve testbench
// Loads L and A through the request port and starts solves under several
// shapes. Each solve result is predicted by forward substitution in Q16.16
// and compared with the emitted words. Random gaps on the request side.
// ----------------------------------------------------------------------------
module tb_complex_lower_triangular_solve_top;
    import cltrs_pkg::*;

    localparam int CYCLE_LIMIT = 30000000;
    localparam int SETTLE      = 40;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        bit        neg;
        bit [63:0] mag;
    } t_smag;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_start;
    t_req       i_req;
    logic       o_busy;
    logic       o_rsp_valid;
    t_rsp       o_rsp;
    logic       i_cfg_valid;
    logic       i_cfg_index;
    logic [3:0] i_cfg_data;
    logic       o_cfg_ready;

    complex_lower_triangular_solve_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_req       (i_req),
        .o_busy      (o_busy),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // predictor state
    longint l_re [8][8];
    longint l_im [8][8];
    longint y_re [8][8];
    longint y_im [8][8];
    logic [3:0] rows_reg = 4'd8;
    logic [3:0] cols_reg = 4'd8;
    bit sat_seen;

    t_req pending_words[$];
    t_rsp expected_y[$];
    bit   l_written [8][8];
    bit   a_written [8][8];
    int   item_cnt   = 0;
    int   mismatches = 0;
    bit   quiet      = 0;
    int   gap        = 0;
    longint cycles   = 0;

    function automatic bit [63:0] amag(longint a);
        return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    function automatic t_smag sm_add(t_smag s, bit n, bit [63:0] m);
        if (s.neg == n) s.mag = s.mag + m;
        else if (s.mag >= m) s.mag = s.mag - m;
        else begin
            s.mag = m - s.mag;
            s.neg = n;
        end
        if (s.mag == 0) s.neg = 0;
        return s;
    endfunction

    function automatic t_smag sm_prod(t_smag s, longint a, longint b, bit negate);
        return sm_add(s, ((a < 0) != (b < 0)) != negate, amag(a) * amag(b));
    endfunction

    function automatic longint clamp32(bit neg, bit [63:0] mag);
        bit [63:0] lim;
        lim = 64'd1 << 31;
        if (neg) begin
            if (mag > lim) begin
                sat_seen = 1;
                mag = lim;
            end
            return -longint'(mag);
        end
        if (mag > lim - 1) begin
            sat_seen = 1;
            mag = lim - 1;
        end
        return longint'(mag);
    endfunction

    // quotient to Q16.16, round half away from zero
    function automatic longint div_q16(t_smag num, bit [63:0] den);
        bit [63:0] q;
        bit [63:0] rem;
        q   = num.mag / den;
        rem = num.mag % den;
        if (q >= (64'd1 << 40)) return clamp32(num.neg, 64'd1 << 63);
        for (int b = 0; b < 16; b++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= den) begin
                rem  = rem - den;
                q[0] = 1'b1;
            end
        end
        if (rem >= den - rem) q = q + 1;
        return clamp32(num.neg, q);
    endfunction

    function automatic longint reduce_comp(longint y, longint a1, longint b1, bit n1,
                                           longint a2, longint b2, bit n2);
        t_smag s;
        bit [63:0] t;
        s = '0;
        t = amag(y);
        s = sm_add(s, y < 0, t << 16);
        s = sm_prod(s, a1, b1, n1);
        s = sm_prod(s, a2, b2, n2);
        return clamp32(s.neg, (s.mag + 64'h8000) >> 16);
    endfunction

    function automatic int eff_size(logic [3:0] v);
        if (v == 0) return 1;
        if (v > 8) return 8;
        return int'(v);
    endfunction

    function automatic void solve_predict();
        int n;
        int m;
        bit zero_seen;
        bit [63:0] den;
        longint dre;
        longint dim;
        longint r1;
        longint i1;
        t_smag nr;
        t_smag ni;
        t_rsp w;
        n = eff_size(rows_reg);
        m = eff_size(cols_reg);
        sat_seen  = 0;
        zero_seen = 0;
        for (int i = 0; i < n; i++) begin
            dre = l_re[i][i];
            dim = l_im[i][i];
            den = amag(dre) * amag(dre) + amag(dim) * amag(dim);
            if (den == 0) begin
                zero_seen = 1;
                for (int j = 0; j < m; j++) begin
                    y_re[i][j] = 0;
                    y_im[i][j] = 0;
                end
                continue;
            end
            for (int j = 0; j < m; j++) begin
                nr = '0;
                ni = '0;
                nr = sm_prod(nr, y_re[i][j], dre, 0);
                nr = sm_prod(nr, y_im[i][j], dim, 0);
                ni = sm_prod(ni, y_im[i][j], dre, 0);
                ni = sm_prod(ni, y_re[i][j], dim, 1);
                r1 = div_q16(nr, den);
                i1 = div_q16(ni, den);
                y_re[i][j] = r1;
                y_im[i][j] = i1;
                for (int k = i + 1; k < n; k++) begin
                    y_re[k][j] = reduce_comp(y_re[k][j], l_re[k][i], r1, 1,
                                             l_im[k][i], i1, 0);
                    y_im[k][j] = reduce_comp(y_im[k][j], l_re[k][i], i1, 1,
                                             l_im[k][i], r1, 1);
                end
            end
        end
        for (int j = 0; j < m; j++) begin
            for (int i = 0; i < n; i++) begin
                w.out_row = 3'(i);
                w.out_col = 3'(j);
                w.y_re    = y_re[i][j][31:0];
                w.y_im    = y_im[i][j][31:0];
                w.status  = zero_seen ? ST_ZERO : (sat_seen ? ST_SAT : ST_OK);
                w.last    = (i == n - 1) && (j == m - 1);
                expected_y.push_back(w);
            end
        end
    endfunction

    function automatic void accept_word(t_req r);
        case (r.req_type)
            REQ_LOAD_L: begin
                l_re[r.row][r.col] = longint'(r.value_re);
                l_im[r.row][r.col] = longint'(r.value_im);
            end
            REQ_LOAD_A: begin
                y_re[r.row][r.col] = longint'(r.value_re);
                y_im[r.row][r.col] = longint'(r.value_im);
            end
            REQ_START: solve_predict();
            default: ;
        endcase
    endfunction

    // driver: hold start until accepted, then advance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
            i_req   <= '0;
        end else begin
            if (i_start && !o_busy) accept_word(i_req);
            if (!i_start || !o_busy) begin
                if (gap > 0) begin
                    gap = gap - 1;
                    i_start <= 1'b0;
                end else if (!quiet && $urandom_range(0, 5) == 0) begin
                    gap = $urandom_range(1, 8) - 1;
                    i_start <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    i_req   <= pending_words.pop_front();
                    i_start <= 1'b1;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // monitor: results cannot be stalled, check each strobe
    always @(posedge i_clk) begin
        t_rsp e;
        if (i_rst_n && o_rsp_valid) begin
            if (expected_y.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: row %0d col %0d",
                             o_rsp.out_row, o_rsp.out_col);
            end else begin
                e = expected_y.pop_front();
                if (o_rsp.out_row !== e.out_row || o_rsp.out_col !== e.out_col ||
                    o_rsp.y_re !== e.y_re || o_rsp.y_im !== e.y_im ||
                    o_rsp.status !== e.status || o_rsp.last !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp r%0d c%0d %h %h st%0d l%0d,",
                                 e.out_row, e.out_col, e.y_re, e.y_im, e.status,
                                 e.last,
                                 " got r%0d c%0d %h %h st%0d l%0d",
                                 o_rsp.out_row, o_rsp.out_col, o_rsp.y_re,
                                 o_rsp.y_im, o_rsp.status, o_rsp.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic push_word(logic [1:0] rt, int r, int c, logic [31:0] re, logic [31:0] im);
        t_req w;
        w.req_type = rt;
        w.row      = 3'(r);
        w.col      = 3'(c);
        w.value_re = re;
        w.value_im = im;
        if (rt == REQ_LOAD_L) l_written[r][c] = 1;
        if (rt == REQ_LOAD_A) a_written[r][c] = 1;
        pending_words.push_back(w);
        item_cnt++;
    endtask

    task automatic wait_idle();
        while (pending_words.size() > 0 || expected_y.size() > 0 || i_start || o_busy)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic idx, logic [3:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        i_cfg_valid <= 1'b0;
        if (idx == CFG_N_ROWS) rows_reg = data;
        else cols_reg = data;
    endtask

    task automatic set_shape(logic [3:0] r, logic [3:0] c);
        wait_idle();
        cfg_write(CFG_N_ROWS, r);
        cfg_write(CFG_N_COLS, c);
    endtask

    function automatic logic [31:0] rand_val(int kind);
        logic [31:0] v;
        case (kind)
            0: v = $urandom;
            1: v = 32'($urandom_range(0, 262143)) - 32'd131072;
            default: begin
                v = 32'($urandom_range(32768, 262144));
                if ($urandom_range(0, 1)) v = -v;
            end
        endcase
        return v;
    endfunction

    // fill entries the solve will read but that were never loaded
    task automatic fill_missing();
        int n;
        int m;
        n = eff_size(rows_reg);
        m = eff_size(cols_reg);
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c <= r; c++)
                if (!l_written[r][c])
                    push_word(REQ_LOAD_L, r, c, rand_val(r == c ? 2 : 1), rand_val(1));
            for (int c = 0; c < m; c++)
                if (!a_written[r][c])
                    push_word(REQ_LOAD_A, r, c, rand_val(1), rand_val(1));
        end
    endtask

    task automatic run_phase();
        int n;
        int m;
        int zrow;
        int kind;
        n = eff_size(rows_reg);
        m = eff_size(cols_reg);
        kind = ($urandom_range(0, 7) == 0) ? 0 : 1;
        zrow = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n - 1) : -1;
        if ($urandom_range(0, 2) != 0) begin
            for (int r = 0; r < n; r++)
                for (int c = 0; c <= r; c++)
                    if (r == zrow && c == r)
                        push_word(REQ_LOAD_L, r, c, 32'd0, 32'd0);
                    else
                        push_word(REQ_LOAD_L, r, c, rand_val(r == c ? (kind ? 2 : 0) : kind),
                                  rand_val(kind));
        end
        if ($urandom_range(0, 2) != 0) begin
            for (int r = 0; r < n; r++)
                for (int c = 0; c < m; c++)
                    push_word(REQ_LOAD_A, r, c, rand_val(kind), rand_val(kind));
        end
        // noise: stray loads and the unused request code
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 2))
                0: push_word(REQ_LOAD_L, $urandom_range(0, 7), $urandom_range(0, 7),
                             $urandom, $urandom);
                1: push_word(REQ_LOAD_A, $urandom_range(0, 7), $urandom_range(0, 7),
                             $urandom, $urandom);
                default: push_word(REQ_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7),
                                   $urandom, $urandom);
            endcase
        end
        fill_missing();
        push_word(REQ_START, $urandom_range(0, 7), $urandom_range(0, 7), $urandom, $urandom);
        if ($urandom_range(0, 4) == 0)
            push_word(REQ_START, 0, 0, 32'd0, 32'd0);
    endtask

    initial begin
        logic [3:0] r;
        logic [3:0] c;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data  = 4'd0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extreme values with a unit first diagonal entry: saturates, then solve again in place
        set_shape(4'd2, 4'd2);
        push_word(REQ_LOAD_L, 0, 0, 32'h0001_0000, 32'h0);
        push_word(REQ_LOAD_L, 1, 0, 32'h8000_0000, 32'h7fff_ffff);
        push_word(REQ_LOAD_L, 1, 1, 32'h0000_0001, 32'hffff_ffff);
        push_word(REQ_LOAD_L, 0, 1, 32'hffff_ffff, 32'h8000_0000);
        push_word(REQ_LOAD_A, 0, 0, 32'h7fff_ffff, 32'h8000_0000);
        push_word(REQ_LOAD_A, 0, 1, 32'h8000_0000, 32'h7fff_ffff);
        push_word(REQ_LOAD_A, 1, 0, 32'h0, 32'hffff_ffff);
        push_word(REQ_LOAD_A, 1, 1, 32'h0001_0000, 32'h0);
        push_word(REQ_UNUSED, 7, 7, 32'hffff_ffff, 32'hffff_ffff);
        push_word(REQ_START, 7, 7, 32'hffff_ffff, 32'hffff_ffff);
        push_word(REQ_START, 0, 0, 32'h0, 32'h0);

        // out-of-range registers act as 1 row and 8 columns; zero diagonal
        set_shape(4'd0, 4'd15);
        push_word(REQ_LOAD_L, 0, 0, 32'h0, 32'h0);
        for (int j = 0; j < 8; j++)
            push_word(REQ_LOAD_A, 0, j, rand_val(0), rand_val(0));
        push_word(REQ_START, 0, 0, 32'h0, 32'h0);

        // full size with a zero diagonal in the middle
        set_shape(4'd8, 4'd1);
        push_word(REQ_LOAD_L, 3, 3, 32'h0, 32'h0);
        fill_missing();
        push_word(REQ_START, 0, 0, 32'h0, 32'h0);

        while (item_cnt < 415) begin
            if (item_cnt > 345) quiet = 1;
            case ($urandom_range(0, 9))
                0: r = 4'd8;
                1: r = $urandom_range(0, 1) ? 4'd0 : 4'd15;
                default: r = 4'($urandom_range(1, 4));
            endcase
            case ($urandom_range(0, 9))
                0: c = 4'd8;
                1: c = $urandom_range(0, 1) ? 4'd0 : 4'd15;
                default: c = 4'($urandom_range(1, 4));
            endcase
            set_shape(r, c);
            run_phase();
        end

        wait_idle();
        mismatches += expected_y.size();
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
